@@ src/dvru_pkg.sv @@
// Shared types and codes for the distance-vector route update unit.
// Used by the slot cells and the top level; depends on nothing.
`default_nettype none

package dvru_pkg;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_OWN     = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_BETTER  = 3'd2,
        ACT_SAMEHOP = 3'd3,
        ACT_KEEP    = 3'd4,
        ACT_FULL    = 3'd5
    } action_t;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_A    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_B    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_C    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OWN_D    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INFINITY = 3'd4;

    // Width of the reported slot index
    localparam int unsigned SLOT_OUT_BITS = 4;

    // Status of the search token as it walks the cell row
    typedef struct packed {
        logic valid;  // token present at this position
        logic hit;    // a valid slot with the destination was seen
        logic free;   // an empty slot was seen
    } probe_flags_t;

endpackage : dvru_pkg

`default_nettype wire

@@ src/dvru_adv_if.sv @@
// Input channel: one advertised route with its link data.
// Depends on nothing.
`default_nettype none

interface dvru_adv_if #(
    parameter int unsigned ADDR_BITS = 32,
    parameter int unsigned COST_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] neighbour_addr;
    logic [ADDR_BITS-1:0] arrival_iface;
    logic [ADDR_BITS-1:0] dest_addr;
    logic [COST_BITS-1:0] advertised_cost;
    logic [COST_BITS-1:0] hop_cost;

    modport source (
        output valid, neighbour_addr, arrival_iface, dest_addr, advertised_cost, hop_cost,
        input  ready
    );
    modport sink (
        input  valid, neighbour_addr, arrival_iface, dest_addr, advertised_cost, hop_cost,
        output ready
    );
endinterface : dvru_adv_if

`default_nettype wire

@@ src/dvru_res_if.sv @@
// Output channel: action, slot index and computed cost of one update.
// Depends on nothing.
`default_nettype none

interface dvru_res_if #(
    parameter int unsigned COST_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [2:0]           action;
    logic [3:0]           slot_index;
    logic [COST_BITS-1:0] computed_cost;

    modport source (
        output valid, action, slot_index, computed_cost,
        input  ready
    );
    modport sink (
        input  valid, action, slot_index, computed_cost,
        output ready
    );
endinterface : dvru_res_if

`default_nettype wire

@@ src/dvru_cell.sv @@
// One route table slot: holds dest, next hop, interface and cost, and
// refines the search token as it passes. Depends on dvru_pkg.
`default_nettype none

module dvru_cell #(
    parameter int unsigned ADDR_BITS = 32,
    parameter int unsigned COST_BITS = 16,
    parameter int unsigned IDX_BITS  = 4,
    parameter int unsigned CELL_IDX  = 0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // search token from the previous cell
    input  wire dvru_pkg::probe_flags_t flags_in,
    input  wire logic [IDX_BITS-1:0]   match_idx_in,
    input  wire logic [IDX_BITS-1:0]   free_idx_in,
    input  wire logic [COST_BITS-1:0]  match_cost_in,
    input  wire logic [ADDR_BITS-1:0]  match_hop_in,
    // search token to the next cell
    output dvru_pkg::probe_flags_t     flags_out,
    output logic [IDX_BITS-1:0]        match_idx_out,
    output logic [IDX_BITS-1:0]        free_idx_out,
    output logic [COST_BITS-1:0]       match_cost_out,
    output logic [ADDR_BITS-1:0]       match_hop_out,
    // broadcast lookup key and slot write
    input  wire logic [ADDR_BITS-1:0]  key_dest,
    input  wire logic                  wr_en,
    input  wire logic [IDX_BITS-1:0]   wr_idx,
    input  wire logic [ADDR_BITS-1:0]  wr_hop,
    input  wire logic [ADDR_BITS-1:0]  wr_iface,
    input  wire logic [COST_BITS-1:0]  wr_cost
);
    import dvru_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic                 valid_reg;
    logic [ADDR_BITS-1:0] dest_reg;
    logic [ADDR_BITS-1:0] hop_reg;
    logic [ADDR_BITS-1:0] iface_reg;
    logic [COST_BITS-1:0] cost_reg;

    probe_flags_t         flags_reg;
    probe_flags_t         flags_next;
    logic [IDX_BITS-1:0]  match_idx_reg;
    logic [IDX_BITS-1:0]  match_idx_next;
    logic [IDX_BITS-1:0]  free_idx_reg;
    logic [IDX_BITS-1:0]  free_idx_next;
    logic [COST_BITS-1:0] match_cost_reg;
    logic [COST_BITS-1:0] match_cost_next;
    logic [ADDR_BITS-1:0] match_hop_reg;
    logic [ADDR_BITS-1:0] match_hop_next;

    logic hit_here;
    logic free_here;
    logic wr_sel;

    // lowest matching slot and lowest empty slot win
    assign hit_here  = valid_reg && (dest_reg == key_dest) && !flags_in.hit;
    assign free_here = !valid_reg && !flags_in.free;
    assign wr_sel    = wr_en && (wr_idx == MY_IDX);

    always_comb
    begin
        flags_next.valid = flags_in.valid;
        flags_next.hit   = flags_in.hit | hit_here;
        flags_next.free  = flags_in.free | free_here;
        match_idx_next   = hit_here  ? MY_IDX    : match_idx_in;
        match_cost_next  = hit_here  ? cost_reg  : match_cost_in;
        match_hop_next   = hit_here  ? hop_reg   : match_hop_in;
        free_idx_next    = free_here ? MY_IDX    : free_idx_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            if (wr_sel)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg  <= match_idx_next;
        free_idx_reg   <= free_idx_next;
        match_cost_reg <= match_cost_next;
        match_hop_reg  <= match_hop_next;
        if (wr_sel)
        begin
            dest_reg  <= key_dest;
            hop_reg   <= wr_hop;
            iface_reg <= wr_iface;
            cost_reg  <= wr_cost;
        end
    end

    assign flags_out      = flags_reg;
    assign match_idx_out  = match_idx_reg;
    assign free_idx_out   = free_idx_reg;
    assign match_cost_out = match_cost_reg;
    assign match_hop_out  = match_hop_reg;

    // iface is stored for the forwarding side; not read by the search
    logic unused_iface;
    assign unused_iface = ^iface_reg;

endmodule : dvru_cell

`default_nettype wire

@@ src/distance_vector_route_update_unit.sv @@
// Distance-vector route update unit: control, cost path and the slot row.
// Depends on dvru_pkg, dvru_adv_if, dvru_res_if and dvru_cell.
//
// Usage:
//   adv (sink): one advertised route per word: neighbour_addr, arrival_iface,
//     dest_addr, advertised_cost, hop_cost. Taken when valid and ready.
//   result (source): one word per route: action, slot_index, computed_cost.
//   cfg_*: write own_addr_a..d (index 0..3) and infinity_cost (index 4)
//     while the unit is idle; other indexes are ignored.
// Timing: one route at a time. Cost and own-address check are registered in
//   ST_CALC, then a search token walks the row of TABLE_DEPTH slot cells, one
//   cell a cycle; an own-address route skips the walk. The slot write is made
//   as the token leaves the last cell, and the result word is loaded from
//   ST_PEND. adv is ready again in the same cycle as the result word turns
//   valid, so the next route starts while the result word waits.
// Reset clears all slot valid marks, own addresses to 0 and infinity to
//   65535. A stalled receiver holds the result word; the unit then holds the
//   following route before its result until the output register empties.
`default_nettype none

module distance_vector_route_update_unit #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned ADDR_BITS   = 32,
    parameter int unsigned COST_BITS   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wen,
    input  wire logic [dvru_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [((ADDR_BITS > COST_BITS) ? ADDR_BITS : COST_BITS)-1:0] cfg_data,
    dvru_adv_if.sink                                   adv,
    dvru_res_if.source                                 result
);
    import dvru_pkg::*;

    localparam int unsigned DATA_BITS = (ADDR_BITS > COST_BITS) ? ADDR_BITS : COST_BITS;
    localparam int unsigned IDX_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_WALK,
        ST_PEND
    } state_t;

    // configuration
    logic [ADDR_BITS-1:0] own_a_reg;
    logic [ADDR_BITS-1:0] own_b_reg;
    logic [ADDR_BITS-1:0] own_c_reg;
    logic [ADDR_BITS-1:0] own_d_reg;
    logic [COST_BITS-1:0] inf_reg;
    logic [ADDR_BITS-1:0] cfg_addr;
    logic [COST_BITS-1:0] cfg_cost;

    assign cfg_addr = ADDR_BITS'(cfg_data & DATA_BITS'(64'hFFFF_FFFF));
    assign cfg_cost = COST_BITS'(cfg_data & DATA_BITS'(64'hFFFF));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_a_reg <= '0;
            own_b_reg <= '0;
            own_c_reg <= '0;
            own_d_reg <= '0;
            inf_reg   <= COST_BITS'(65535);
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_OWN_A:    own_a_reg <= cfg_addr;
                REG_OWN_B:    own_b_reg <= cfg_addr;
                REG_OWN_C:    own_c_reg <= cfg_addr;
                REG_OWN_D:    own_d_reg <= cfg_addr;
                REG_INFINITY: inf_reg   <= cfg_cost;
                default:      ;
            endcase
        end
    end

    // control and result registers
    state_t               state_reg;
    logic                 res_valid_reg;
    action_t              res_action_reg;
    logic [IDX_BITS-1:0]  res_slot_reg;
    logic [COST_BITS-1:0] res_cost_reg;
    action_t              pend_action_reg;
    logic [IDX_BITS-1:0]  pend_slot_reg;

    // item payload
    logic [ADDR_BITS-1:0] nbr_reg;
    logic [ADDR_BITS-1:0] iface_reg;
    logic [ADDR_BITS-1:0] dest_reg;
    logic [COST_BITS-1:0] adv_cost_reg;
    logic [COST_BITS-1:0] hop_cost_reg;
    logic [COST_BITS-1:0] cost_reg;

    logic adv_fire;
    logic res_free;
    assign adv.ready = (state_reg == ST_IDLE);
    assign adv_fire  = adv.valid && adv.ready;
    assign res_free  = !res_valid_reg || result.ready;

    // saturated path cost and own-address check
    logic [COST_BITS:0]   cost_sum;
    logic [COST_BITS-1:0] cost_calc;
    logic                 is_own;

    assign cost_sum = {1'b0, adv_cost_reg} + {1'b0, hop_cost_reg};

    always_comb
    begin
        if (adv_cost_reg >= inf_reg)
        begin
            cost_calc = inf_reg;
        end
        else if (cost_sum >= {1'b0, inf_reg})
        begin
            cost_calc = inf_reg;
        end
        else
        begin
            cost_calc = cost_sum[COST_BITS-1:0];
        end
    end

    assign is_own = (dest_reg == own_a_reg) || (dest_reg == own_b_reg) ||
                    (dest_reg == own_c_reg) || (dest_reg == own_d_reg);

    // slot cell row
    probe_flags_t         chain_flags [TABLE_DEPTH+1];
    logic [IDX_BITS-1:0]  chain_midx  [TABLE_DEPTH+1];
    logic [IDX_BITS-1:0]  chain_fidx  [TABLE_DEPTH+1];
    logic [COST_BITS-1:0] chain_mcost [TABLE_DEPTH+1];
    logic [ADDR_BITS-1:0] chain_mhop  [TABLE_DEPTH+1];

    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;

    // inject the token as the cost is settled
    assign chain_flags[0].valid = (state_reg == ST_CALC) && !is_own;
    assign chain_flags[0].hit   = 1'b0;
    assign chain_flags[0].free  = 1'b0;
    assign chain_midx[0]        = '0;
    assign chain_fidx[0]        = '0;
    assign chain_mcost[0]       = '0;
    assign chain_mhop[0]        = '0;

    for (genvar g = 0; g < TABLE_DEPTH; g++)
    begin : g_cell
        dvru_cell #(
            .ADDR_BITS (ADDR_BITS),
            .COST_BITS (COST_BITS),
            .IDX_BITS  (IDX_BITS),
            .CELL_IDX  (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .flags_in       (chain_flags[g]),
            .match_idx_in   (chain_midx[g]),
            .free_idx_in    (chain_fidx[g]),
            .match_cost_in  (chain_mcost[g]),
            .match_hop_in   (chain_mhop[g]),
            .flags_out      (chain_flags[g+1]),
            .match_idx_out  (chain_midx[g+1]),
            .free_idx_out   (chain_fidx[g+1]),
            .match_cost_out (chain_mcost[g+1]),
            .match_hop_out  (chain_mhop[g+1]),
            .key_dest       (dest_reg),
            .wr_en          (wr_en),
            .wr_idx         (wr_idx),
            .wr_hop         (nbr_reg),
            .wr_iface       (iface_reg),
            .wr_cost        (cost_reg)
        );
    end

    // decision on the token leaving the last cell
    probe_flags_t         tail;
    logic                 tail_done;
    action_t              dec_action;
    logic [IDX_BITS-1:0]  dec_slot;

    assign tail      = chain_flags[TABLE_DEPTH];
    assign tail_done = (state_reg == ST_WALK) && tail.valid;

    always_comb
    begin
        dec_action = ACT_FULL;
        dec_slot   = '0;
        wr_en      = 1'b0;
        if (tail.hit)
        begin
            dec_slot = chain_midx[TABLE_DEPTH];
            if (cost_reg < chain_mcost[TABLE_DEPTH])
            begin
                dec_action = ACT_BETTER;
                wr_en      = tail_done;
            end
            else if (chain_mhop[TABLE_DEPTH] == nbr_reg)
            begin
                dec_action = ACT_SAMEHOP;
                wr_en      = tail_done;
            end
            else
            begin
                dec_action = ACT_KEEP;
            end
        end
        else if (tail.free)
        begin
            dec_slot   = chain_fidx[TABLE_DEPTH];
            dec_action = ACT_INSERT;
            wr_en      = tail_done;
        end
    end

    assign wr_idx = dec_slot;

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // load a new word, else drop the one just taken
            if ((state_reg == ST_PEND) && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.valid && result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (adv_fire)
                    begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC:
                begin
                    state_reg <= is_own ? ST_PEND : ST_WALK;
                end
                ST_WALK:
                begin
                    if (tail.valid)
                    begin
                        state_reg <= ST_PEND;
                    end
                end
                ST_PEND:
                begin
                    if (res_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_fire)
        begin
            nbr_reg      <= adv.neighbour_addr;
            iface_reg    <= adv.arrival_iface;
            dest_reg     <= adv.dest_addr;
            adv_cost_reg <= adv.advertised_cost;
            hop_cost_reg <= adv.hop_cost;
        end
        if (state_reg == ST_CALC)
        begin
            cost_reg        <= cost_calc;
            pend_action_reg <= ACT_OWN;
            pend_slot_reg   <= '0;
        end
        if (tail_done)
        begin
            pend_action_reg <= dec_action;
            pend_slot_reg   <= dec_slot;
        end
        if ((state_reg == ST_PEND) && res_free)
        begin
            res_action_reg <= pend_action_reg;
            res_slot_reg   <= pend_slot_reg;
            res_cost_reg   <= cost_reg;
        end
    end

    // report the slot index in four bits
    logic [IDX_BITS+SLOT_OUT_BITS-1:0] slot_wide;
    assign slot_wide = {{SLOT_OUT_BITS{1'b0}}, res_slot_reg};

    assign result.valid         = res_valid_reg;
    assign result.action        = res_action_reg;
    assign result.slot_index    = slot_wide[SLOT_OUT_BITS-1:0];
    assign result.computed_cost = res_cost_reg;

endmodule : distance_vector_route_update_unit

`default_nettype wire
